// File: rtl/mecanum_command_parser_mixer_macros.svh
// Assertion macros shared by the mecanum command parser and mixer RTL.
`ifndef MECANUM_COMMAND_PARSER_MIXER_MACROS_SVH
`define MECANUM_COMMAND_PARSER_MIXER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCPM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MCPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mcpm_pkg.sv
// Shared constants and types for the mecanum command parser and mixer.
`timescale 1ns / 1ps

package mcpm_pkg;

  localparam int CMD_W       = 16;            // stored joystick command width
  localparam int CTR_W       = 18;            // centred command width
  localparam int MIX_W       = 20;            // mixed wheel sum width
  localparam int SPEED_W     = 8;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;

  // received characters
  localparam logic [7:0] CHAR_X     = 8'h78;
  localparam logic [7:0] CHAR_Y     = 8'h79;
  localparam logic [7:0] CHAR_W     = 8'h77;
  localparam logic [7:0] CHAR_B     = 8'h62;
  localparam logic [7:0] CHAR_V     = 8'h76;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  localparam logic signed [CMD_W-1:0] CMD_CENTRE = 16'sd128;

  // values that follow the b command
  localparam logic signed [CMD_W-1:0] AUX_SET_A = 16'sd1;
  localparam logic signed [CMD_W-1:0] AUX_SET_B = 16'sd2;
  localparam logic signed [CMD_W-1:0] AUX_CLR_A = 16'sd3;
  localparam logic signed [CMD_W-1:0] AUX_CLR_B = 16'sd4;

  typedef struct packed {
    logic ld_ctr;   // sample the commands into the centring stage
    logic ld_out;   // load the result register
  } pipe_ctrl_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic               fwd;
  } wheel_t;

  // packed so that wheel one sits in the lowest bits
  typedef struct packed {
    logic   aux_b;
    logic   aux_a;
    wheel_t w4;
    wheel_t w3;
    wheel_t w2;
    wheel_t w1;
  } result_t;

endpackage

// File: rtl/mcpm_parser.sv
// Command byte parser: number accumulation, command registers and aux levels.
`timescale 1ns / 1ps

module mcpm_parser (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  logic [7:0]                          rx_byte,
  output logic signed [mcpm_pkg::CMD_W-1:0]   lateral,
  output logic signed [mcpm_pkg::CMD_W-1:0]   forward,
  output logic signed [mcpm_pkg::CMD_W-1:0]   turn,
  output logic                                aux_a,
  output logic                                aux_b
);
  import mcpm_pkg::*;

  localparam int MAG_W = 15;
  localparam int ACC_W = MAG_W + 4;
  localparam logic [MAG_W-1:0] MAG_LIMIT = 15'd32767;

  typedef enum logic [3:0] {
    PH_START  = 4'b0001,
    PH_SIGN   = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_STOP   = 4'b1000
  } phase_t;

  logic                    receiving_r, receiving_nxt;
  phase_t                  phase_r, phase_nxt;
  logic                    negative_r, negative_nxt;
  logic [MAG_W-1:0]        mag_r, mag_nxt;
  logic signed [CMD_W-1:0] lateral_r, lateral_nxt;
  logic signed [CMD_W-1:0] forward_r, forward_nxt;
  logic signed [CMD_W-1:0] turn_r, turn_nxt;
  logic                    aux_a_r, aux_a_nxt;
  logic                    aux_b_r, aux_b_nxt;

  logic                    is_digit, is_cmd, is_space;
  logic [3:0]              digit_val;
  logic [ACC_W-1:0]        mag_acc;
  logic [MAG_W-1:0]        mag_sat;
  logic signed [CMD_W-1:0] value;

  assign is_digit  = rx_byte inside {[CHAR_ZERO:CHAR_NINE]};
  assign is_cmd    = rx_byte inside {CHAR_X, CHAR_Y, CHAR_W, CHAR_B, CHAR_V, CHAR_TAB};
  assign is_space  = rx_byte inside {CHAR_SPACE, [CHAR_LF:CHAR_CR]};
  assign digit_val = rx_byte[3:0];

  // magnitude*10 + digit, saturated
  assign mag_acc = ({4'b0, mag_r} * ACC_W'(10)) + ACC_W'(digit_val);
  assign mag_sat = (mag_acc > ACC_W'(MAG_LIMIT)) ? MAG_LIMIT : mag_acc[MAG_W-1:0];

  assign value = negative_r ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});

  always_comb begin
    receiving_nxt = receiving_r;
    phase_nxt     = phase_r;
    negative_nxt  = negative_r;
    mag_nxt       = mag_r;
    lateral_nxt   = lateral_r;
    forward_nxt   = forward_r;
    turn_nxt      = turn_r;
    aux_a_nxt     = aux_a_r;
    aux_b_nxt     = aux_b_r;
    if (step) begin
      if (!is_cmd) begin
        receiving_nxt = 1'b1;
        case (phase_r)
          PH_START: begin
            if (is_space) begin
              phase_nxt = PH_START;
            end else if (rx_byte == CHAR_PLUS || rx_byte == CHAR_MINUS) begin
              negative_nxt = (rx_byte == CHAR_MINUS);
              phase_nxt    = PH_SIGN;
            end else if (is_digit) begin
              mag_nxt   = MAG_W'(digit_val);
              phase_nxt = PH_DIGITS;
            end else begin
              phase_nxt = PH_STOP;
            end
          end
          PH_SIGN, PH_DIGITS: begin
            if (is_digit) begin
              mag_nxt   = mag_sat;
              phase_nxt = PH_DIGITS;
            end else begin
              phase_nxt = PH_STOP;
            end
          end
          default: begin
            phase_nxt = PH_STOP;
          end
        endcase
      end else if (receiving_r) begin
        case (rx_byte)
          CHAR_X: lateral_nxt = value;
          CHAR_Y: forward_nxt = value;
          CHAR_W: turn_nxt    = value;
          CHAR_B: begin
            if (value == AUX_SET_A) begin
              aux_a_nxt = 1'b1;
            end else if (value == AUX_SET_B) begin
              aux_b_nxt = 1'b1;
            end else if (value == AUX_CLR_A) begin
              aux_a_nxt = 1'b0;
            end else if (value == AUX_CLR_B) begin
              aux_b_nxt = 1'b0;
            end
          end
          CHAR_TAB: receiving_nxt = 1'b0;
          default: ;
        endcase
        phase_nxt    = PH_START;
        negative_nxt = 1'b0;
        mag_nxt      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      receiving_r <= 1'b0;
      phase_r     <= PH_START;
      negative_r  <= 1'b0;
      mag_r       <= '0;
      lateral_r   <= CMD_CENTRE;
      forward_r   <= CMD_CENTRE;
      turn_r      <= CMD_CENTRE;
      aux_a_r     <= 1'b0;
      aux_b_r     <= 1'b0;
    end else begin
      receiving_r <= receiving_nxt;
      phase_r     <= phase_nxt;
      negative_r  <= negative_nxt;
      mag_r       <= mag_nxt;
      lateral_r   <= lateral_nxt;
      forward_r   <= forward_nxt;
      turn_r      <= turn_nxt;
      aux_a_r     <= aux_a_nxt;
      aux_b_r     <= aux_b_nxt;
    end
  end

  assign lateral = lateral_r;
  assign forward = forward_r;
  assign turn    = turn_r;
  assign aux_a   = aux_a_r;
  assign aux_b   = aux_b_r;

endmodule

// File: rtl/mcpm_mixer.sv
// Joystick centring stage, mecanum mix, clamp and result register.
`timescale 1ns / 1ps

module mcpm_mixer (
  input  logic                               clk,
  input  mcpm_pkg::pipe_ctrl_t               ctrl,
  input  logic signed [mcpm_pkg::CMD_W-1:0]  lateral,
  input  logic signed [mcpm_pkg::CMD_W-1:0]  forward,
  input  logic signed [mcpm_pkg::CMD_W-1:0]  turn,
  input  logic                               aux_a,
  input  logic                               aux_b,
  output mcpm_pkg::result_t                  result
);
  import mcpm_pkg::*;

  // d/127 as (d * RECIP_127) >> RECIP_SHIFT, exact for d below 2^15
  localparam int RECIP_W     = 24;
  localparam int RECIP_SHIFT = 30;
  localparam int PROD_W      = CMD_W + RECIP_W;
  localparam int Q_W         = PROD_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP_127 = 24'd8454661;
  localparam logic signed [MIX_W-1:0] WHEEL_MAX = 20'sd255;

  // Above centre: 2d + d/127. Below centre: -(2e - ceil(e/128)).
  function automatic logic signed [CTR_W-1:0] centre_value(
    input logic signed [CMD_W-1:0] cmd
  );
    logic signed [CMD_W:0] d;
    logic signed [CMD_W:0] nd;
    logic [CMD_W-1:0]      pos;
    logic [CMD_W-1:0]      neg;
    logic [PROD_W-1:0]     prod;
    logic [Q_W-1:0]        q;
    logic [CMD_W-1:0]      up;
    logic [CTR_W-1:0]      mag;
    d    = {cmd[CMD_W-1], cmd} - {CMD_CENTRE[CMD_W-1], CMD_CENTRE};
    nd   = -d;
    pos  = d[CMD_W-1:0];
    neg  = nd[CMD_W-1:0];
    prod = PROD_W'(pos) * PROD_W'(RECIP_127);
    q    = prod[RECIP_SHIFT +: Q_W];
    up   = (neg + CMD_W'(127)) >> 7;
    if (d == '0) begin
      centre_value = '0;
    end else if (d > 0) begin
      mag          = {1'b0, pos, 1'b0} + CTR_W'(q);
      centre_value = $signed(mag);
    end else begin
      mag          = {1'b0, neg, 1'b0} - CTR_W'(up);
      centre_value = -$signed(mag);
    end
  endfunction

  function automatic wheel_t put_wheel(input logic signed [MIX_W-1:0] v);
    logic signed [MIX_W-1:0] c;
    logic signed [MIX_W-1:0] m;
    wheel_t                  w;
    if (v > WHEEL_MAX) begin
      c = WHEEL_MAX;
    end else if (v < -WHEEL_MAX) begin
      c = -WHEEL_MAX;
    end else begin
      c = v;
    end
    m       = (c < 0) ? -c : c;
    w.fwd   = (c > 0);
    w.speed = m[SPEED_W-1:0];
    put_wheel = w;
  endfunction

  logic signed [CTR_W-1:0] vx_r, vy_r, tw_r;
  logic                    aux_a_r, aux_b_r;
  logic signed [MIX_W-1:0] vx, vy, tw;
  result_t                 result_r, result_nxt;

  always_ff @(posedge clk) begin
    if (ctrl.ld_ctr) begin
      vx_r    <= centre_value(lateral);
      vy_r    <= centre_value(forward);
      tw_r    <= centre_value(turn);
      aux_a_r <= aux_a;
      aux_b_r <= aux_b;
    end
  end

  assign vx = MIX_W'(vx_r);
  assign vy = MIX_W'(vy_r);
  assign tw = MIX_W'(tw_r);

  always_comb begin
    result_nxt.w1    = put_wheel(vy - vx - tw);
    result_nxt.w2    = put_wheel(vy + vx + tw);
    result_nxt.w3    = put_wheel(vy - vx + tw);
    result_nxt.w4    = put_wheel(vy + vx - tw);
    result_nxt.aux_a = aux_a_r;
    result_nxt.aux_b = aux_b_r;
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_out) begin
      result_r <= result_nxt;
    end
  end

  assign result = result_r;

endmodule

// File: rtl/mecanum_command_parser_mixer.sv
// Top level of the mecanum command parser and wheel mixer.
`timescale 1ns / 1ps
`include "mecanum_command_parser_mixer_macros.svh"

// Usage:
//   in_*  : one received byte per transfer (command letter, tab or number text).
//   out_* : one wheel result per input byte: direction and speed for four wheels
//           plus the two auxiliary levels, reflecting state after that byte.
// Pipeline of four registered stages, each with its own valid bit:
//   byte register -> parser state update -> centring (one constant multiply
//   per axis) -> mix, clamp and result register.
// Throughput: one byte per cycle while out_tready stays high; the parser
// state update is the only loop.
// Stall: each stage advances when the stage after it is empty or moving, so
// the block keeps taking bytes into empty stages while a result waits on
// out_tready; once all four stages are full, in_tready drops.
// Reset: rst_n low clears all valid bits and the parser state; commands come
// back at centre (128), so the first result shows all wheels stopped.
module mecanum_command_parser_mixer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mcpm_pkg::IN_TDATA_W-1:0]     in_tdata,   // [7:0] rx_byte
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] wheel1_forward, [8:1] wheel1_speed, [9] wheel2_forward,
  // [17:10] wheel2_speed, [18] wheel3_forward, [26:19] wheel3_speed,
  // [27] wheel4_forward, [35:28] wheel4_speed, [36] aux_out_a,
  // [37] aux_out_b, [39:38] zero
  output logic [mcpm_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import mcpm_pkg::*;

  logic                    v0_r, v1_r, v2_r, v3_r;
  logic [IN_TDATA_W-1:0]   byte_r;
  logic                    rdy0, rdy1, rdy2, rdy3;
  logic                    accept, step, move12, move23;
  pipe_ctrl_t              ctrl;
  logic signed [CMD_W-1:0] lateral, forward, turn;
  logic                    aux_a, aux_b;
  result_t                 result;

  // Each stage frees up when empty or when it hands its item on.
  assign rdy3   = !v3_r || out_tready;
  assign rdy2   = !v2_r || rdy3;
  assign rdy1   = !v1_r || rdy2;
  assign rdy0   = !v0_r || rdy1;
  assign move23 = v2_r && rdy3;
  assign move12 = v1_r && rdy2;
  assign step   = v0_r && rdy1;
  assign accept = in_tvalid && rdy0;

  assign in_tready = rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_tvalid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // Hold the byte until the parser takes it.
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_tdata;
    end
  end

  mcpm_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (byte_r),
    .lateral (lateral),
    .forward (forward),
    .turn    (turn),
    .aux_a   (aux_a),
    .aux_b   (aux_b)
  );

  assign ctrl.ld_ctr = move12;
  assign ctrl.ld_out = move23;

  mcpm_mixer u_mixer (
    .clk     (clk),
    .ctrl    (ctrl),
    .lateral (lateral),
    .forward (forward),
    .turn    (turn),
    .aux_a   (aux_a),
    .aux_b   (aux_b),
    .result  (result)
  );

  assign out_tvalid = v3_r;
  assign out_tdata  = {(OUT_TDATA_W - $bits(result_t))'(0), result};

  // Parser state moves only when a byte steps into it.
  `MCPM_ASSERT_NEXT(a_state_hold, clk, rst_n, !step, $stable(lateral) && $stable(forward) && $stable(turn) && $stable(aux_a) && $stable(aux_b), "parser state changed without a byte")
  // A blocked state stage keeps its item.
  `MCPM_ASSERT_NEXT(a_stage1_hold, clk, rst_n, v1_r && !rdy2, v1_r, "state stage lost its item while stalled")
  // A wheel marked forward always has a nonzero speed.
  `MCPM_ASSERT_SAME(a_fwd_speed, clk, rst_n, out_tvalid && (result.w1.fwd || result.w2.fwd || result.w3.fwd || result.w4.fwd), (!result.w1.fwd || result.w1.speed != '0) && (!result.w2.fwd || result.w2.speed != '0) && (!result.w3.fwd || result.w3.speed != '0) && (!result.w4.fwd || result.w4.speed != '0), "forward wheel with zero speed")

endmodule
